/* design/rmac_pkg.sv */
// Shared types, constants and the Liu-Layland bound table for the admission controller.
`default_nettype none

package rmac_pkg;

    localparam int NUM_PRIORITIES = 32;
    localparam int PRIO_W         = 5;
    localparam int TIME_W         = 16;
    localparam int UTIL_W         = 17;
    localparam int COUNT_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int DIV_STEPS      = UTIL_W;

    localparam logic [PRIO_W-1:0] IDLE_PRIORITY = PRIO_W'(NUM_PRIORITIES - 1);

    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [NUM_PRIORITIES-1:0] mask_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BAD_PRIO = 2'd1;
    localparam status_t ST_TAKEN    = 2'd2;
    localparam status_t ST_OVER     = 2'd3;

    typedef struct packed {
        logic    load;
        logic    init;
        logic    reject;
        status_t code;
        logic    step;
        logic    commit;
    } cmd_t;

    typedef struct packed {
        logic is_init;
        logic bad_prio;
        logic taken;
        logic sat;
        logic div_last;
        logic over_bound;
    } sts_t;

    function automatic logic [UTIL_W-1:0] bound_q16(input logic [COUNT_W-1:0] idx);
        logic [UTIL_W-1:0] b;
        case (idx)
            5'd0:    b = 17'd65536;
            5'd1:    b = 17'd54264;
            5'd2:    b = 17'd51053;
            5'd3:    b = 17'd49545;
            5'd4:    b = 17'd48693;
            5'd5:    b = 17'd48103;
            5'd6:    b = 17'd47776;
            5'd7:    b = 17'd47448;
            5'd8:    b = 17'd47251;
            5'd9:    b = 17'd47055;
            5'd10:   b = 17'd46858;
            5'd11:   b = 17'd46793;
            5'd12:   b = 17'd46662;
            5'd13:   b = 17'd46596;
            5'd14:   b = 17'd46465;
            5'd15:   b = 17'd46399;
            5'd16:   b = 17'd46334;
            5'd17:   b = 17'd46334;
            5'd18:   b = 17'd46268;
            5'd19:   b = 17'd46203;
            5'd20:   b = 17'd46203;
            5'd21:   b = 17'd46137;
            5'd22:   b = 17'd46137;
            5'd23:   b = 17'd46072;
            5'd24:   b = 17'd46072;
            5'd25:   b = 17'd46006;
            5'd26:   b = 17'd46006;
            5'd27:   b = 17'd46006;
            default: b = 17'd45941;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* design/rmac_if.sv */
// Request and response channel interfaces of the admission controller.
`default_nettype none

interface rmac_req_if;
    import rmac_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] exec_time;
    logic [TIME_W-1:0] period;

    modport source (output valid, op, prio, exec_time, period, input ready);
    modport sink   (input valid, op, prio, exec_time, period, output ready);
endinterface

interface rmac_rsp_if;
    import rmac_pkg::*;
    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  task_count;
    logic [UTIL_W-1:0]   util_sum;
    logic [NUM_PRIORITIES-1:0] runnable_mask;

    modport source (output valid, status, task_count, util_sum, runnable_mask, input ready);
    modport sink   (input valid, status, task_count, util_sum, runnable_mask, output ready);
endinterface

`default_nettype wire

/* design/rmac_ctrl.sv */
// Sequencing state machine: check, divide, commit or reject, present result.
`default_nettype none

module rmac_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire rmac_pkg::sts_t sts,
    output rmac_pkg::cmd_t     cmd
);
    import rmac_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_OUT;
                if (sts.is_init)
                begin
                    cmd.init = 1'b1;
                end
                else if (sts.bad_prio)
                begin
                    cmd.reject = 1'b1;
                    cmd.code   = ST_BAD_PRIO;
                end
                else if (sts.taken)
                begin
                    cmd.reject = 1'b1;
                    cmd.code   = ST_TAKEN;
                end
                else if (sts.sat)
                begin
                    cmd.reject = 1'b1;
                    cmd.code   = ST_OVER;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_OUT;
                if (sts.over_bound)
                begin
                    cmd.reject = 1'b1;
                    cmd.code   = ST_OVER;
                end
                else
                begin
                    cmd.commit = 1'b1;
                end
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a result is pending");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && sts.div_last |=> (state_reg == S_FINISH))
        else $error("divider did not hand off to finish");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.init, cmd.reject, cmd.commit}))
        else $error("conflicting result actions");

endmodule

`default_nettype wire

/* design/rmac_datapath.sv */
// Task-set state, restoring divider for utilization and bound check.
`default_nettype none

module rmac_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rmac_pkg::cmd_t                cmd,
    output rmac_pkg::sts_t                     sts,
    input  wire logic                          op,
    input  wire logic [rmac_pkg::PRIO_W-1:0]   prio,
    input  wire logic [rmac_pkg::TIME_W-1:0]   exec_time,
    input  wire logic [rmac_pkg::TIME_W-1:0]   period,
    output logic [rmac_pkg::STATUS_W-1:0]      status,
    output logic [rmac_pkg::COUNT_W-1:0]       task_count,
    output logic [rmac_pkg::UTIL_W-1:0]        util_sum,
    output logic [rmac_pkg::NUM_PRIORITIES-1:0] runnable_mask
);
    import rmac_pkg::*;

    logic              op_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TIME_W-1:0] c_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [UTIL_W-1:0] quo_reg;
    logic [COUNT_W-1:0] cnt_reg;
    status_t           status_reg;

    mask_t              taken_mask_reg;
    mask_t              ready_mask_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [UTIL_W-1:0]  total_reg;

    logic              shift_bit;
    logic [TIME_W:0]   rem_shift;
    logic [TIME_W+1:0] rem_diff;
    logic [UTIL_W:0]   total_sum;
    mask_t             prio_bit;

    assign shift_bit = (cnt_reg == COUNT_W'(DIV_STEPS - 1)) ? c_reg[0] : 1'b0;
    assign rem_shift = {rem_reg, shift_bit};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, t_reg};
    assign total_sum = {1'b0, total_reg} + {1'b0, quo_reg};
    assign prio_bit  = mask_t'(1) << prio_reg;

    assign sts.is_init    = !op_reg;
    assign sts.bad_prio   = (prio_reg >= IDLE_PRIORITY);
    assign sts.taken      = taken_mask_reg[prio_reg];
    // quotient overflows 17 bits exactly when C >= 2T; a zero period lands here
    assign sts.sat        = ({1'b0, c_reg} >= {t_reg, 1'b0});
    assign sts.div_last   = (cnt_reg == '0);
    assign sts.over_bound = (total_sum > {1'b0, bound_q16(count_reg)});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            prio_reg <= prio;
            c_reg    <= exec_time;
            t_reg    <= period;
            rem_reg  <= {1'b0, exec_time[TIME_W-1:1]};
            quo_reg  <= '0;
            cnt_reg  <= COUNT_W'(DIV_STEPS - 1);
        end
        else if (cmd.step)
        begin
            if (!rem_diff[TIME_W+1])
            begin
                rem_reg <= rem_diff[TIME_W-1:0];
                quo_reg <= {quo_reg[UTIL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[TIME_W-1:0];
                quo_reg <= {quo_reg[UTIL_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - COUNT_W'(1);
        end
        if (cmd.init || cmd.commit)
        begin
            status_reg <= ST_OK;
        end
        else if (cmd.reject)
        begin
            status_reg <= cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_mask_reg <= '0;
            ready_mask_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
        end
        else if (cmd.init)
        begin
            taken_mask_reg <= taken_mask_reg | (mask_t'(1) << IDLE_PRIORITY);
            ready_mask_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            taken_mask_reg <= taken_mask_reg | prio_bit;
            ready_mask_reg <= ready_mask_reg | prio_bit;
            count_reg      <= count_reg + COUNT_W'(1);
            total_reg      <= total_sum[UTIL_W-1:0];
        end
    end

    assign status        = status_reg;
    assign task_count    = count_reg;
    assign util_sum      = total_reg;
    assign runnable_mask = ready_mask_reg;

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("admitted count did not advance on commit");

    a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> (ready_mask_reg == '0) && (count_reg == '0) && (total_reg == '0))
        else $error("init did not clear the task set");

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 17'd65536)
        else $error("admitted utilization above one");

endmodule

`default_nettype wire

/* design/rm_admission_control.sv */
// Top level of the rate-monotonic admission controller.
//
//  channel | dir | beat fields
//  --------+-----+-------------------------------------------------
//  req     | in  | op, prio, exec_time, period
//  rsp     | out | status, task_count, util_sum, runnable_mask
//
// One request at a time. Init and creates rejected on priority, a taken slot,
// a zero period or a share of two or more go from the check state straight to
// the result; any other create runs the 17-step restoring divider for
// exec_time / period and then the finish state. A stalled result holds rsp and
// keeps req ready low. Reset clears the task set and the controller.
`default_nettype none

module rm_admission_control (
    input  wire logic clk,
    input  wire logic rst_n,
    rmac_req_if.sink  req,
    rmac_rsp_if.source rsp
);
    import rmac_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rmac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rmac_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (req.op),
        .prio          (req.prio),
        .exec_time     (req.exec_time),
        .period        (req.period),
        .status        (rsp.status),
        .task_count    (rsp.task_count),
        .util_sum      (rsp.util_sum),
        .runnable_mask (rsp.runnable_mask)
    );

endmodule

`default_nettype wire
